// File: hdl/fvc_pkg.sv
// ----------------------------------------------------------------------------
// Frame validator package
// Shared constants, codes, the queue entry type and the byte-wide CRC
// update functions of the frame validator.
// ----------------------------------------------------------------------------
package fvc_pkg;

	// Frame layout and limits.
	localparam logic [7:0]  SYNC_FIRST    = 8'h7E;
	localparam logic [7:0]  SYNC_SECOND   = 8'h81;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1400;
	localparam int          CNT_W         = 17;
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [CNT_W-1:0] HDR_BYTES = 17'd20;
	localparam logic [CNT_W-1:0] MIN_BYTES = 17'd24;
	localparam logic [15:0] CRC16_POLY    = 16'h1021;
	localparam logic [31:0] CRC32_POLY    = 32'h04C11DB7;

	// Operation codes that the front end attaches to each byte.
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_HDR  = 3'd1;
	localparam logic [2:0] OP_SEQ  = 3'd2;
	localparam logic [2:0] OP_HCRC = 3'd3;
	localparam logic [2:0] OP_PAY  = 3'd4;
	localparam logic [2:0] OP_TRL  = 3'd5;

	// Status codes of a result.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_BAD_SYNC = 3'd2;
	localparam logic [2:0] ST_HDR_CRC  = 3'd3;
	localparam logic [2:0] ST_TOO_BIG  = 3'd4;
	localparam logic [2:0] ST_PAY_CRC  = 3'd5;

	// One classified byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] op;
		logic       sync_bad;
		logic       last;
		logic       short_hdr;
		logic       short_len;
		logic       too_big;
	} fvc_item_t;

	// CRC-16/CCITT-FALSE update by one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// CRC-32/MPEG-2 update by one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC32_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: hdl/fvc_rx_if.sv
// ----------------------------------------------------------------------------
// Frame validator byte channel
// Valid/ready channel that carries one received byte and its last mark.
// ----------------------------------------------------------------------------
interface fvc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/fvc_res_if.sv
// ----------------------------------------------------------------------------
// Frame validator result channel
// Valid/ready channel that carries the status and header fields of a frame.
// ----------------------------------------------------------------------------
interface fvc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  channel;
	logic [7:0]  msg_type;
	logic [15:0] payload_len;
	logic [31:0] seq_number;
	logic [31:0] rig_ident;

	modport source (output valid, output status, output channel, output msg_type,
		output payload_len, output seq_number, output rig_ident, input ready);
	modport sink   (input valid, input status, input channel, input msg_type,
		input payload_len, input seq_number, input rig_ident, output ready);
endinterface

// File: hdl/fvc_front.sv
// ----------------------------------------------------------------------------
// Frame validator front end
// Accepts bytes, tracks the byte position and payload length, and tags each
// byte with the operation that the back end must perform on it.
// ----------------------------------------------------------------------------
module fvc_front (
	input  logic              clk,
	input  logic              arst_n,
	fvc_rx_if.sink            rx,
	input  logic [15:0]       max_len,
	output fvc_pkg::fvc_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import fvc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      plen_q;
	logic [CNT_W-1:0] cnt_nx;
	logic [CNT_W-1:0] pay_pos;
	logic [CNT_W:0]   trl_end;
	logic [CNT_W:0]   min_len;
	logic             accept;

	assign rx.ready   = item_ready;
	assign item_valid = rx.valid;
	assign accept     = rx.valid && item_ready;

	// Count after this byte, saturating.
	assign cnt_nx  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 17'd1;
	assign pay_pos = cnt_q - HDR_BYTES;
	assign trl_end = {2'b00, plen_q} + 18'd4;
	assign min_len = {1'b0, MIN_BYTES} + {2'b00, plen_q};

	// Classify the byte by its position in the frame.
	always_comb begin
		item.data      = rx.data_byte;
		item.last      = rx.last_byte;
		item.sync_bad  = ((cnt_q == 17'd0) && (rx.data_byte != SYNC_FIRST)) ||
			((cnt_q == 17'd1) && (rx.data_byte != SYNC_SECOND));
		item.short_hdr = cnt_nx < MIN_BYTES;
		item.short_len = {1'b0, cnt_nx} < min_len;
		item.too_big   = plen_q > max_len;
		item.op        = OP_NONE;
		if (cnt_q < 17'd8) begin
			item.op = OP_HDR;
		end else if (cnt_q < 17'd16) begin
			item.op = OP_SEQ;
		end else if (cnt_q < 17'd18) begin
			item.op = OP_HCRC;
		end else if ((cnt_q >= HDR_BYTES) && (cnt_q != CNT_MAX)) begin
			if (pay_pos < {1'b0, plen_q}) begin
				item.op = OP_PAY;
			end else if ({1'b0, pay_pos} < trl_end) begin
				item.op = OP_TRL;
			end
		end
	end

	// Position counter and payload length capture; both clear at the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			plen_q <= '0;
		end else if (accept) begin
			if (rx.last_byte) begin
				cnt_q  <= '0;
				plen_q <= '0;
			end else begin
				cnt_q <= cnt_nx;
				if (cnt_q == 17'd4) begin
					plen_q[15:8] <= rx.data_byte;
				end
				if (cnt_q == 17'd5) begin
					plen_q[7:0] <= rx.data_byte;
				end
			end
		end
	end

endmodule

// File: hdl/fvc_queue.sv
// ----------------------------------------------------------------------------
// Frame validator queue
// Short first-in first-out queue of classified bytes between the front end
// and the back end.
// ----------------------------------------------------------------------------
module fvc_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fvc_pkg::fvc_item_t push_item,
	input  logic               push_valid,
	output logic               push_ready,
	output fvc_pkg::fvc_item_t pop_item,
	output logic               pop_valid,
	input  logic               pop_ready
);
	import fvc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	fvc_item_t         entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_QW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/fvc_back.sv
// ----------------------------------------------------------------------------
// Frame validator back end
// Runs the header and payload CRCs, collects the header fields and, at the
// last byte of a frame, registers the status and fields for the result.
// ----------------------------------------------------------------------------
module fvc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fvc_pkg::fvc_item_t item,
	input  logic               item_valid,
	output logic               item_ready,
	fvc_res_if.source          res
);
	import fvc_pkg::*;

	logic        sync_ok_q;
	logic [63:0] hdr_q;
	logic [63:0] seq_rig_q;
	logic [15:0] hcrc_rx_q;
	logic [15:0] hcrc_q;
	logic [31:0] pcrc_q;
	logic [31:0] trl_q;
	logic        res_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  channel_q;
	logic [7:0]  msg_type_q;
	logic [15:0] plen_q;
	logic [31:0] seq_q;
	logic [31:0] rig_q;
	logic [31:0] trl_nx;
	logic [2:0]  status_nx;
	logic        pop;

	// A last byte waits until the result register is free.
	assign item_ready = !item.last || !res_valid_q || res.ready;
	assign pop        = item_valid && item_ready;

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.channel     = channel_q;
	assign res.msg_type    = msg_type_q;
	assign res.payload_len = plen_q;
	assign res.seq_number  = seq_q;
	assign res.rig_ident   = rig_q;

	// The last byte may itself complete the trailer word.
	assign trl_nx = (item.op == OP_TRL) ? {trl_q[23:0], item.data} : trl_q;

	// Checks in priority order.
	always_comb begin
		if (item.short_hdr) begin
			status_nx = ST_SHORT;
		end else if (!sync_ok_q) begin
			status_nx = ST_BAD_SYNC;
		end else if (hcrc_q != hcrc_rx_q) begin
			status_nx = ST_HDR_CRC;
		end else if (item.too_big) begin
			status_nx = ST_TOO_BIG;
		end else if (item.short_len) begin
			status_nx = ST_SHORT;
		end else if (pcrc_q != trl_nx) begin
			status_nx = ST_PAY_CRC;
		end else begin
			status_nx = ST_OK;
		end
	end

	// Frame state: updated per byte, cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_ok_q <= 1'b1;
			hdr_q     <= '0;
			seq_rig_q <= '0;
			hcrc_rx_q <= '0;
			hcrc_q    <= 16'hFFFF;
			pcrc_q    <= 32'hFFFFFFFF;
			trl_q     <= '0;
		end else if (pop) begin
			if (item.last) begin
				sync_ok_q <= 1'b1;
				hdr_q     <= '0;
				seq_rig_q <= '0;
				hcrc_rx_q <= '0;
				hcrc_q    <= 16'hFFFF;
				pcrc_q    <= 32'hFFFFFFFF;
				trl_q     <= '0;
			end else begin
				case (item.op)
					OP_HDR: begin
						hcrc_q <= crc16_byte(hcrc_q, item.data);
						hdr_q  <= {hdr_q[55:0], item.data};
						if (item.sync_bad) begin
							sync_ok_q <= 1'b0;
						end
					end
					OP_SEQ:  seq_rig_q <= {seq_rig_q[55:0], item.data};
					OP_HCRC: hcrc_rx_q <= {hcrc_rx_q[7:0], item.data};
					OP_PAY:  pcrc_q <= crc32_byte(pcrc_q, item.data);
					OP_TRL:  trl_q <= trl_nx;
					default: ;
				endcase
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; a frame under the minimum size reports zero fields.
	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			status_q <= status_nx;
			if (item.short_hdr) begin
				channel_q  <= '0;
				msg_type_q <= '0;
				plen_q     <= '0;
				seq_q      <= '0;
				rig_q      <= '0;
			end else begin
				channel_q  <= hdr_q[47:40];
				msg_type_q <= hdr_q[39:32];
				plen_q     <= hdr_q[31:16];
				seq_q      <= seq_rig_q[63:32];
				rig_q      <= seq_rig_q[31:0];
			end
		end
	end

endmodule

// File: hdl/frame_validator_crc16_crc32.sv
// A last byte passes through the queue, and the back end registers its result when it pops that byte.
// Throughput: one byte per cycle; the byte after a last byte waits only while the
// previous result is still held by a stalled result channel and the queue is full.
// The queue between the front and back ends holds QUEUE_DEPTH bytes.
// Reset clears all frame state and sets the payload limit to 1400.
// ----------------------------------------------------------------------------
// Frame validator top level
// Checks sync bytes, header CRC-16, payload length and payload CRC-32 of a
// byte stream and reports one status per frame.
// ----------------------------------------------------------------------------
module frame_validator_crc16_crc32 #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	fvc_rx_if.sink      rx,
	fvc_res_if.source   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import fvc_pkg::*;

	logic [15:0] max_len_q;
	fvc_item_t   f_item;
	logic        f_valid;
	logic        f_ready;
	fvc_item_t   b_item;
	logic        b_valid;
	logic        b_ready;

	// Payload length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Front end: position tracking and byte classification.
	fvc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.max_len    (max_len_q),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	// Queue between the two ends.
	fvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	// Back end: CRCs, field capture and result register.
	fvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (b_item),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.res        (res)
	);

endmodule

// File: hdl/fvc_checker.sv
// ----------------------------------------------------------------------------
// Frame validator checker
// Port-level assertions on the frame validator, attached by a bind.
// ----------------------------------------------------------------------------
module fvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        rx_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_status,
	input logic [7:0]  res_channel,
	input logic [7:0]  res_msg_type,
	input logic [15:0] res_len,
	input logic [31:0] res_seq,
	input logic [31:0] res_rig,
	input logic        cfg_we,
	input logic [15:0] cfg_wdata
);
	import fvc_pkg::*;

	logic [15:0] lim_q;
	logic [2:0]  pend_q;
	logic        last_in;
	logic        res_out;

	assign last_in = rx_valid && rx_ready && rx_last;
	assign res_out = res_valid && res_ready;

	// Mirror of the payload limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	// Frames accepted whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (last_in && !res_out) begin
			pend_q <= pend_q + 3'd1;
		end else if (res_out && !last_in) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// A stalled result keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) &&
		$stable(res_channel) && $stable(res_msg_type) && $stable(res_len) &&
		$stable(res_seq) && $stable(res_rig))
		else $error("result changed while stalled");

	// Every result belongs to a frame whose last byte was accepted.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 3'd0)
		else $error("result without a pending frame");

	// A frame reported good respects the payload limit.
	a_ok_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_OK |-> res_len <= lim_q)
		else $error("good frame over the payload limit");

	// Status codes stay within the defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status <= ST_PAY_CRC)
		else $error("undefined status code");

endmodule

bind frame_validator_crc16_crc32 fvc_checker u_fvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.rx_last      (rx.last_byte),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_status   (res.status),
	.res_channel  (res.channel),
	.res_msg_type (res.msg_type),
	.res_len      (res.payload_len),
	.res_seq      (res.seq_number),
	.res_rig      (res.rig_ident),
	.cfg_we       (cfg_we),
	.cfg_wdata    (cfg_wdata)
);

// File: dv/fvc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator verification package
// Bit-serial CRC-16/CCITT-FALSE and CRC-32/MPEG-2 updates, shared by the
// frame builder of the testbench and the status predictor of the checker.
// ----------------------------------------------------------------------------
package fvc_tb_pkg;

	localparam logic [15:0] CCITT_POLY = 16'h1021;
	localparam logic [31:0] MPEG2_POLY = 32'h04C11DB7;

	// CRC-16/CCITT-FALSE, one data bit at a time, most significant bit first.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
		end
		return c;
	endfunction

	// CRC-32/MPEG-2, one data bit at a time, most significant bit first.
	function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[31] ^ b[k];
			c  = {c[30:0], 1'b0} ^ (fb ? MPEG2_POLY : 32'h00000000);
		end
		return c;
	endfunction

endpackage

// File: dv/frame_validator_crc16_crc32_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator checker
// Watches the byte, result and register channels, predicts the status and
// header fields of every buffer, and compares each result transaction with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module frame_validator_crc16_crc32_checker (
	input  logic        clk,
	input  logic        arst_n,
	fvc_rx_if           rx,
	fvc_res_if          res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          expected_left
);
	import fvc_pkg::*;
	import fvc_tb_pkg::*;

	localparam int COUNT_LIMIT = 131071;
	localparam int HEADER_LEN  = 20;
	localparam int MIN_FRAME   = 24;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  channel;
		logic [7:0]  msg_type;
		logic [15:0] payload_len;
		logic [31:0] seq_number;
		logic [31:0] rig_ident;
	} frame_report_t;

	// Predicted results, oldest first.
	frame_report_t expected_q[$];

	// Running state of the buffer being received.
	int          rx_count;
	logic        sync_seen_ok;
	logic [63:0] hdr_bytes;
	logic [63:0] seq_rig_bytes;
	logic [15:0] hcrc_field;
	logic [15:0] hcrc_run;
	logic [31:0] pcrc_run;
	logic [31:0] trailer_word;
	logic [15:0] max_len;

	task automatic clear_frame_state();
		rx_count      = 0;
		sync_seen_ok  = 1'b1;
		hdr_bytes     = '0;
		seq_rig_bytes = '0;
		hcrc_field    = '0;
		hcrc_run      = 16'hFFFF;
		pcrc_run      = 32'hFFFFFFFF;
		trailer_word  = '0;
	endtask

	// Fold one accepted byte into the frame state; on the last byte, queue
	// the predicted result and start afresh.
	task automatic absorb_byte(input logic [7:0] b, input logic is_last);
		int            pos;
		int            plen;
		int            off;
		frame_report_t rep;
		pos  = rx_count;
		plen = int'(hdr_bytes[31:16]);
		if (pos < 8) begin
			hcrc_run  = crc16_next(hcrc_run, b);
			hdr_bytes = {hdr_bytes[55:0], b};
			if (pos == 0 && b != 8'h7E)
				sync_seen_ok = 1'b0;
			if (pos == 1 && b != 8'h81)
				sync_seen_ok = 1'b0;
		end else if (pos < 16) begin
			seq_rig_bytes = {seq_rig_bytes[55:0], b};
		end else if (pos < 18) begin
			hcrc_field = {hcrc_field[7:0], b};
		end else if (pos >= HEADER_LEN && pos < COUNT_LIMIT) begin
			// Payload bytes feed the CRC, the next four form the trailer and
			// anything after that is ignored.
			off = pos - HEADER_LEN;
			if (off < plen)
				pcrc_run = crc32_next(pcrc_run, b);
			else if (off < plen + 4)
				trailer_word = {trailer_word[23:0], b};
		end
		if (rx_count < COUNT_LIMIT)
			rx_count++;
		if (is_last) begin
			rep = '0;
			if (rx_count < MIN_FRAME) begin
				rep.status = ST_SHORT;
			end else begin
				plen            = int'(hdr_bytes[31:16]);
				rep.channel     = hdr_bytes[47:40];
				rep.msg_type    = hdr_bytes[39:32];
				rep.payload_len = hdr_bytes[31:16];
				rep.seq_number  = seq_rig_bytes[63:32];
				rep.rig_ident   = seq_rig_bytes[31:0];
				// The checks take priority in this order.
				if (!sync_seen_ok)
					rep.status = ST_BAD_SYNC;
				else if (hcrc_run != hcrc_field)
					rep.status = ST_HDR_CRC;
				else if (plen > int'(max_len))
					rep.status = ST_TOO_BIG;
				else if (rx_count < MIN_FRAME + plen)
					rep.status = ST_SHORT;
				else if (pcrc_run != trailer_word)
					rep.status = ST_PAY_CRC;
				else
					rep.status = ST_OK;
			end
			expected_q.push_back(rep);
			clear_frame_state();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_report();
		frame_report_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result with no buffer pending, status %0h", $time, res.status);
			fail_count++;
		end else begin
			want = expected_q.pop_front();
			compare_field("status", 32'(want.status), 32'(res.status));
			compare_field("channel", 32'(want.channel), 32'(res.channel));
			compare_field("msg_type", 32'(want.msg_type), 32'(res.msg_type));
			compare_field("payload_len", 32'(want.payload_len), 32'(res.payload_len));
			compare_field("seq_number", want.seq_number, res.seq_number);
			compare_field("rig_ident", want.rig_ident, res.rig_ident);
		end
	endtask

	// Sample every channel at the rising edge, before the block updates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			max_len    = MAX_LEN_RESET;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_we)
				max_len = cfg_wdata;
			if (res.valid && res.ready)
				check_report();
			if (rx.valid && rx.ready)
				absorb_byte(rx.data_byte, rx.last_byte);
		end
		expected_left = expected_q.size();
	end

endmodule

// File: dv/frame_validator_crc16_crc32_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator testbench
// Sends directed and random buffers (good frames, damaged headers, bad
// CRCs, cut and over-long buffers, noise) through the byte channel under
// varied idling on both sides and payload limits, and leaves the checking
// to the checker module.
// ----------------------------------------------------------------------------
module frame_validator_crc16_crc32_tb;
	import fvc_pkg::*;
	import fvc_tb_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_BYTES   = 330;

	typedef enum {
		FK_GOOD, FK_EXTRA, FK_TRUNC, FK_PAY_CRC, FK_HDR_CRC,
		FK_SYNC_A, FK_SYNC_B, FK_TOO_BIG, FK_SHORT, FK_NOISE
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          fail_count;
	int          expected_left;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_go;
	logic [15:0] cur_limit;
	logic [7:0]  frame_bytes[$];

	fvc_rx_if  rx();
	fvc_res_if res();

	frame_validator_crc16_crc32 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	frame_validator_crc16_crc32_checker status_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx),
		.res           (res),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Safety net against a hung handshake.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result receiver: random stalls, or one long hold-off on request.
	initial begin
		bit held;
		held      = 1'b0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				res.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	// Offer one byte, with random idle cycles first, and wait for its transaction.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			rx.valid     <= 1'b0;
			rx.data_byte <= 8'($urandom);
			@(negedge clk);
		end
		rx.valid     <= 1'b1;
		rx.data_byte <= b;
		rx.last_byte <= is_last;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_range(input int lo, input int hi);
		for (int k = lo; k <= hi; k++)
			send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
	endtask

	// Let every pending result arrive and the block run dry.
	task automatic settle();
		rx.valid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		cur_limit  = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Assemble one buffer of the given kind into frame_bytes.
	task automatic build_frame(input frame_kind_t kind, input int plen, input logic [7:0] ch,
		input logic [7:0] ty, input logic [31:0] seq, input logic [31:0] rig);
		logic [15:0] len16;
		logic [15:0] hcrc;
		logic [31:0] pcrc;
		logic [7:0]  b;
		int          fill;
		int          cut;
		frame_bytes.delete();
		if (kind == FK_NOISE) begin
			fill = $urandom_range(64, 1);
			repeat (fill) frame_bytes.push_back(8'($urandom));
		end else begin
			len16       = 16'(plen);
			frame_bytes = '{8'h7E, 8'h81, ch, ty, len16[15:8], len16[7:0],
				8'($urandom), 8'($urandom)};
			if (kind == FK_SYNC_A)
				frame_bytes[0] ^= 8'($urandom_range(255, 1));
			if (kind == FK_SYNC_B)
				frame_bytes[1] ^= 8'($urandom_range(255, 1));
			hcrc = 16'hFFFF;
			for (int k = 0; k < 8; k++)
				hcrc = crc16_next(hcrc, frame_bytes[k]);
			if (kind == FK_HDR_CRC)
				hcrc ^= 16'($urandom_range(16'hFFFF, 1));
			for (int k = 3; k >= 0; k--)
				frame_bytes.push_back(seq[8*k +: 8]);
			for (int k = 3; k >= 0; k--)
				frame_bytes.push_back(rig[8*k +: 8]);
			frame_bytes.push_back(hcrc[15:8]);
			frame_bytes.push_back(hcrc[7:0]);
			frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(8'($urandom));
			// An over-long length is reported before the payload matters,
			// so only a few payload bytes are sent for it.
			fill = (kind == FK_TOO_BIG && plen > 12) ? 12 : plen;
			pcrc = 32'hFFFFFFFF;
			repeat (fill) begin
				b = 8'($urandom);
				frame_bytes.push_back(b);
				pcrc = crc32_next(pcrc, b);
			end
			if (kind == FK_PAY_CRC)
				pcrc ^= $urandom_range(32'hFFFFFFFF, 1);
			for (int k = 3; k >= 0; k--)
				frame_bytes.push_back(pcrc[8*k +: 8]);
			case (kind)
				FK_EXTRA: begin
					repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom));
				end
				FK_TRUNC: begin
					cut         = $urandom_range(23 + plen, 24);
					frame_bytes = frame_bytes[0:cut-1];
				end
				FK_SHORT: begin
					cut         = $urandom_range(23, 1);
					frame_bytes = frame_bytes[0:cut-1];
				end
				default: ;
			endcase
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input int plen, input logic [7:0] ch,
		input logic [7:0] ty, input logic [31:0] seq, input logic [31:0] rig);
		build_frame(kind, plen, ch, ty, seq, rig);
		send_range(0, frame_bytes.size() - 1);
	endtask

	// Random frames: well-formed ones with random content, the rest damaged or noise.
	task automatic random_frame();
		int          pick;
		int          plen;
		int          most;
		frame_kind_t kind;
		pick = $urandom_range(99, 0);
		if (pick < 35)      kind = FK_GOOD;
		else if (pick < 43) kind = FK_EXTRA;
		else if (pick < 51) kind = FK_TRUNC;
		else if (pick < 59) kind = FK_PAY_CRC;
		else if (pick < 66) kind = FK_HDR_CRC;
		else if (pick < 70) kind = FK_SYNC_A;
		else if (pick < 74) kind = FK_SYNC_B;
		else if (pick < 81) kind = FK_TOO_BIG;
		else if (pick < 91) kind = FK_SHORT;
		else                kind = FK_NOISE;
		most = (cur_limit < 24) ? int'(cur_limit) : 24;
		plen = $urandom_range(most, 0);
		if (kind == FK_TRUNC && most == 0)
			kind = FK_SHORT;
		if (kind == FK_TRUNC && plen == 0)
			plen = 1;
		if (kind == FK_TOO_BIG) begin
			if (cur_limit == 16'hFFFF)
				kind = FK_GOOD;
			else
				plen = $urandom_range(65535, int'(cur_limit) + 1);
		end
		send_frame(kind, plen, 8'($urandom), 8'($urandom), $urandom, $urandom);
	endtask

	// Stimulus: reset, directed buffers, then four random phases.
	initial begin
		int          sent;
		logic [15:0] lim;
		bit          pressed;
		rx.valid       = 1'b0;
		rx.data_byte   = '0;
		rx.last_byte   = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go        = 1'b0;
		pressed        = 1'b0;
		cur_limit      = MAX_LEN_RESET;
		arst_n         = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Good frames at the smallest size and with all-zero and all-one fields.
		send_frame(FK_GOOD, 0, 8'h00, 8'h00, 32'h0, 32'h0);
		send_frame(FK_GOOD, 5, 8'hFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		// Buffers of one byte and of one byte under the minimum.
		build_frame(FK_GOOD, 0, 8'h01, 8'h02, 32'h1, 32'h2);
		frame_bytes = frame_bytes[0:0];
		send_range(0, 0);
		build_frame(FK_GOOD, 0, 8'h01, 8'h02, 32'h1, 32'h2);
		frame_bytes = frame_bytes[0:22];
		send_range(0, 22);
		// Damaged headers and a length just over the default limit.
		send_frame(FK_SYNC_A, 3, 8'h00, 8'h11, $urandom, $urandom);
		send_frame(FK_SYNC_B, 3, 8'h01, 8'h22, $urandom, $urandom);
		send_frame(FK_HDR_CRC, 3, 8'h01, 8'h33, $urandom, $urandom);
		send_frame(FK_TOO_BIG, 1401, 8'h00, 8'h44, $urandom, $urandom);
		// A length equal to the default limit passes the limit check; the
		// buffer is cut soon after the header, so it is reported short.
		build_frame(FK_GOOD, 1400, 8'h01, 8'h55, $urandom, $urandom);
		frame_bytes = frame_bytes[0:29];
		send_range(0, 29);
		// Buffers that end before the trailer is complete, at both ends of that range.
		build_frame(FK_GOOD, 10, 8'h00, 8'h66, $urandom, $urandom);
		frame_bytes = frame_bytes[0:23];
		send_range(0, 23);
		build_frame(FK_GOOD, 10, 8'h01, 8'h77, $urandom, $urandom);
		frame_bytes = frame_bytes[0:32];
		send_range(0, 32);
		send_frame(FK_PAY_CRC, 7, 8'h00, 8'h88, $urandom, $urandom);
		send_frame(FK_EXTRA, 3, 8'h01, 8'h99, $urandom, $urandom);
		send_frame(FK_NOISE, 0, 8'h00, 8'h00, 32'h0, 32'h0);

		// Limit lowered part-way through a buffer: the final byte sees it.
		build_frame(FK_GOOD, 20, 8'h00, 8'hAA, $urandom, $urandom);
		send_range(0, 29);
		settle();
		write_limit(16'd10);
		send_range(30, frame_bytes.size() - 1);
		settle();

		// Zero limit: only empty payloads pass.
		write_limit(16'h0000);
		send_frame(FK_GOOD, 0, 8'h01, 8'hBB, $urandom, $urandom);
		send_frame(FK_TOO_BIG, 1, 8'h00, 8'hCC, $urandom, $urandom);
		settle();

		// Largest payload length under the largest limit, cut after the header.
		write_limit(16'hFFFF);
		build_frame(FK_GOOD, 65535, 8'h01, 8'hDD, $urandom, $urandom);
		frame_bytes = frame_bytes[0:39];
		send_range(0, 39);

		// Random phases under different idling and limits.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: lim = MAX_LEN_RESET;
				1: lim = 16'd12;
				2: lim = 16'($urandom_range(16'hFFFF, 0));
				default: lim = 16'hFFFF;
			endcase
			settle();
			write_limit(lim);
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct  = 22;
					recv_stall_pct = 22;
				end
			endcase
			sent = 0;
			while (sent < PHASE_BYTES) begin
				// Hold off the receiver while short buffers keep coming, so
				// the block fills and stops taking bytes.
				if (ph == 0 && !pressed && sent > PHASE_BYTES / 2) begin
					pressed = 1'b1;
					hold_go = 1'b1;
					repeat (8) begin
						send_frame(FK_SHORT, 0, 8'($urandom), 8'($urandom),
							$urandom, $urandom);
						sent += frame_bytes.size();
					end
				end
				random_frame();
				sent += frame_bytes.size();
			end
		end

		settle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
